FILE: hw/rtl/sha1de_pkg.sv
// Shared types, constants and round functions of the SHA-1 digest engine.
package sha1de_pkg;

    // Command that the front end hands to the compression back end.
    typedef enum logic [0:0] {
        CMD_BYTE   = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    // One queue entry: a message byte, or a finish with its length snapshot.
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data;
        logic        ovf;
        logic [63:0] count;
    } t_qent;

    localparam logic [4:0][31:0] INIT_CHAIN = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD  = 3'd4;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;

    // Round constant for round t.
    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20) begin
            k = 32'h5A827999;
        end else if (t < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (t < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

    // Boolean mixing function for round t.
    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

FILE: hw/rtl/sha1de_front.sv
// Front end: accepts input transactions, keeps the bit count and queues commands.
module sha1de_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_kind,
    input  logic [7:0]          i_data_byte,
    input  logic                i_q_full,
    output logic                o_stall,
    output logic                o_push,
    output sha1de_pkg::t_qent   o_entry
);

    logic [63:0] r_bit_count;
    logic        r_ovf;
    logic [63:0] n_bit_count;
    logic        w_accept;

    assign o_stall     = i_q_full;
    assign w_accept    = i_valid && !i_q_full;
    assign n_bit_count = r_bit_count + 64'd8;

    // Bytes that arrive after the length overflowed are dropped here.
    assign o_push = w_accept && (i_kind || !r_ovf);

    always_comb begin
        o_entry.cmd   = i_kind ? sha1de_pkg::CMD_FINISH : sha1de_pkg::CMD_BYTE;
        o_entry.data  = i_data_byte;
        o_entry.ovf   = r_ovf;
        o_entry.count = r_bit_count;
    end

    // Length tracking; a finish starts a new message.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= '0;
            r_ovf       <= 1'b0;
        end else if (w_accept) begin
            if (i_kind) begin
                r_bit_count <= '0;
                r_ovf       <= 1'b0;
            end else if (!r_ovf) begin
                r_bit_count <= n_bit_count;
                if (n_bit_count == 64'd0) begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/sha1de_fifo.sv
// Short command queue between the front end and the compression back end.
module sha1de_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sha1de_pkg::t_qent   i_entry,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output sha1de_pkg::t_qent   o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sha1de_pkg::t_qent r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_entry   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/sha1de_core.sv
// Back end: block buffer, padding sequencer, 80-round compression and digest output.
module sha1de_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  sha1de_pkg::t_qent   i_entry,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_last_word,
    output logic                o_status
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state       r_state;
    logic [31:0]  r_w [16];
    logic [31:0]  r_chain [5];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [6:0]   r_round;
    logic [5:0]   r_pos;
    logic         r_fin;
    logic         r_extra;
    logic         r_ovf;
    logic [63:0]  r_count;
    logic [2:0]   r_idx;

    logic [31:0]  n_t;
    logic [31:0]  n_w;
    logic [63:0]  w_len_shift;
    logic [7:0]   w_pad_byte;
    logic [7:0]   w_wr_byte;
    logic         w_wr_en;
    logic         w_out_take;

    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign w_out_take = (r_state == S_OUT) && !i_stall;

    // Round datapath and message schedule over a 16-word sliding window.
    assign n_t = {r_a[26:0], r_a[31:27]} + sha1de_pkg::round_f(r_round, r_b, r_c, r_d)
               + r_e + r_w[0] + sha1de_pkg::round_k(r_round);
    assign n_w = {r_w[13][30:0] ^ r_w[8][30:0] ^ r_w[2][30:0] ^ r_w[0][30:0],
                  r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};

    // Padding byte: zeros, then the big-endian bit count in the last eight bytes.
    assign w_len_shift = r_count << {r_pos[2:0], 3'b000};
    assign w_pad_byte  = (!r_extra && (r_pos >= sha1de_pkg::LEN_POS)) ?
                         w_len_shift[63:56] : 8'h00;

    // Byte written into the block buffer this cycle.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_byte = w_pad_byte;
        if (o_pop && !(i_entry.cmd == sha1de_pkg::CMD_FINISH && i_entry.ovf)) begin
            w_wr_en   = 1'b1;
            w_wr_byte = (i_entry.cmd == sha1de_pkg::CMD_FINISH) ?
                        sha1de_pkg::PAD_BYTE : i_entry.data;
        end else if (r_state == S_PAD) begin
            w_wr_en = 1'b1;
        end
    end

    // Block buffer: byte writes while filling, window shift while compressing.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_w;
        end else if (w_wr_en) begin
            r_w[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= w_wr_byte;
        end
    end

    // Sequencer for intake, padding, compression and output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_fin   <= 1'b0;
            r_extra <= 1'b0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_round <= '0;
            for (int i = 0; i < 5; i++) begin
                r_chain[i] <= sha1de_pkg::INIT_CHAIN[i];
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_count <= i_entry.count;
                        if (i_entry.cmd == sha1de_pkg::CMD_FINISH && i_entry.ovf) begin
                            r_ovf   <= 1'b1;
                            r_idx   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_fin   <= (i_entry.cmd == sha1de_pkg::CMD_FINISH);
                            r_extra <= (r_pos >= sha1de_pkg::LEN_POS);
                            r_pos   <= r_pos + 1'b1;
                            if (r_pos == sha1de_pkg::LAST_POS) begin
                                r_round <= '0;
                                r_state <= S_ROUND;
                            end else if (i_entry.cmd == sha1de_pkg::CMD_FINISH) begin
                                r_state <= S_PAD;
                            end
                        end
                    end
                end
                S_PAD: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == sha1de_pkg::LAST_POS) begin
                        r_round <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 1'b1;
                    if (r_round == sha1de_pkg::LAST_ROUND) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_chain[4] <= r_chain[4] + r_e;
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_extra) begin
                        r_extra <= 1'b0;
                        r_state <= S_PAD;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_take) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == sha1de_pkg::LAST_WORD) begin
                            r_pos   <= '0;
                            r_fin   <= 1'b0;
                            r_extra <= 1'b0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                            for (int i = 0; i < 5; i++) begin
                                r_chain[i] <= sha1de_pkg::INIT_CHAIN[i];
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Working variables: loaded from the chain value, then one round per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROUND) begin
            r_a <= n_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end else begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end
    end

    // Digest words come straight from the chain registers (zero after a length overflow) and hold while stalled.
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_ovf ? 32'h0 : r_chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == sha1de_pkg::LAST_WORD);
    assign o_status      = r_ovf;

endmodule

FILE: hw/rtl/sha1_digest_engine_unit.sv
// SHA-1 digest engine top level: front end, command queue and compression back end.
// A byte transaction is written into the block buffer; a full block then runs the 80 rounds
// in one shared round unit, followed by the chain add. Unless the length overflowed, a
// finish pads one byte per cycle (with a second compression when more than 55 bytes are
// pending); five digest words then follow, one per cycle while the output is not stalled.
// Input transactions keep flowing into the queue while the back end works or waits, until the queue is full.
// Reset (synchronous, active low) restores the initial chain value and empties the queue.
module sha1_digest_engine_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_status
);

    sha1de_pkg::t_qent w_push_entry;
    sha1de_pkg::t_qent w_pop_entry;
    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_q_empty;

    // Front end classifies transactions and tracks the message length.
    sha1de_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_q_full    (w_q_full),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    // Command queue decouples the two sides.
    sha1de_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_entry (w_pop_entry)
    );

    // Back end pads, compresses and emits the digest.
    sha1de_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_entry       (w_pop_entry),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word),
        .o_status      (o_status)
    );

    // The last digest word ends the output burst.
    a_burst_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_word) |=> !o_valid)
        else $error("output valid after last digest word");

    // Words of one digest follow each other in order.
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_word) |=>
            (o_valid && (o_word_index == $past(o_word_index) + 3'd1)))
        else $error("digest word sequence broken");

    // The last-word flag marks exactly the fifth word.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd4)))
        else $error("last word flag does not match word index");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the SHA-1 digest engine: byte streams in, digest words checked.
module testbench;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_IDLE      = 13;
    localparam int ITEM_TARGET   = 300;
    localparam int SETTLE_CYCLES = 300;
    localparam int RUN_LIMIT     = 1_000_000;

    // SHA-1 initial chaining value, word 0 in the top bits, and the round constants.
    localparam logic [159:0] SHA1_IV = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    // One expected digest transaction.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
        logic        status;
    } t_digest_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic        i_kind      = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;
    logic        o_status;

    // Hash state of the predictor.
    logic [31:0]  hash_state [5];
    logic [7:0]   block_bytes [64];
    logic [5:0]   fill_pos;
    logic [63:0]  length_bits;
    logic         length_overflow;
    t_digest_word digest_q [$];

    // Run bookkeeping; calm turns off idling on both sides for a stretch.
    logic        calm = 1'b0;
    int unsigned error_count    = 0;
    int unsigned words_checked  = 0;
    int unsigned items_sent     = 0;
    int unsigned messages_done  = 0;
    longint unsigned longest_msg = 0;

    sha1_digest_engine_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word),
        .o_status      (o_status)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop in case the engine hangs.
    initial begin
        #(RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Put the predictor back into its power-up state.
    function automatic void model_reset();
        int i;
        for (i = 0; i < 5; i++) begin
            hash_state[i] = SHA1_IV[159 - 32 * i -: 32];
        end
        for (i = 0; i < 64; i++) begin
            block_bytes[i] = 8'h00;
        end
        fill_pos        = '0;
        length_bits     = '0;
        length_overflow = 1'b0;
    endfunction

    // Run the 80-round compression over the buffered block.
    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4 * i], block_bytes[4 * i + 1],
                    block_bytes[4 * i + 2], block_bytes[4 * i + 3]};
        end
        for (i = 16; i < 80; i++) begin
            w[i] = rotl(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = rotl(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // Apply one accepted transaction to the predictor and queue any digest words.
    function automatic void absorb_item(input sha1de_pkg::t_cmd kind, input logic [7:0] data);
        t_digest_word dw;
        int p;
        int i;
        if (kind == sha1de_pkg::CMD_BYTE) begin
            // Bytes arriving after a length overflow are dropped until the next finish.
            if (!length_overflow) begin
                block_bytes[fill_pos] = data;
                fill_pos    = fill_pos + 6'd1;
                length_bits = length_bits + 64'd8;
                if (length_bits == '0) begin
                    length_overflow = 1'b1;
                end
                if (fill_pos == '0) begin
                    sha1_compress();
                end
            end
        end else begin
            if (length_bits / 8 > longest_msg) begin
                longest_msg = length_bits / 8;
            end
            // Padding: marker byte, zeros, then the big-endian bit count, with an
            // extra block when the count no longer fits behind the marker.
            if (!length_overflow) begin
                p = fill_pos;
                block_bytes[p] = PAD_MARK;
                p++;
                if (p > 56) begin
                    while (p < 64) begin
                        block_bytes[p] = 8'h00;
                        p++;
                    end
                    sha1_compress();
                    p = 0;
                end
                while (p < 56) begin
                    block_bytes[p] = 8'h00;
                    p++;
                end
                for (i = 0; i < 8; i++) begin
                    block_bytes[56 + i] = length_bits[63 - 8 * i -: 8];
                end
                sha1_compress();
            end
            for (i = 0; i < 5; i++) begin
                dw.word   = length_overflow ? 32'h0 : hash_state[i];
                dw.index  = 3'(i);
                dw.last   = (i == 4);
                dw.status = length_overflow;
                digest_q.push_back(dw);
            end
            messages_done++;
            model_reset();
        end
    endfunction

    // Send one transaction after a random gap; returns at the falling edge after acceptance.
    task automatic send_item(input sha1de_pkg::t_cmd kind, input logic [7:0] data);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        absorb_item(kind, data);
        items_sent++;
        @(negedge i_clk);
    endtask

    // A message of random bytes followed by a finish with a random, ignored data byte.
    task automatic send_message(input int len);
        int n;
        for (n = 0; n < len; n++) begin
            send_item(sha1de_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
        end
        send_item(sha1de_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Hold the input side quiet until every predicted digest word has been seen.
    task automatic wait_until_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (digest_q.size() != 0) @(negedge i_clk);
    endtask

    // Empty messages, back to back, with the ignored data byte at both extremes.
    task automatic test_empty_message();
        calm = 1'b1;
        send_item(sha1de_pkg::CMD_FINISH, 8'hFF);
        send_item(sha1de_pkg::CMD_FINISH, 8'h00);
        calm = 1'b0;
    endtask

    // The classic three-byte message.
    task automatic test_abc_message();
        send_item(sha1de_pkg::CMD_BYTE, 8'h61);
        send_item(sha1de_pkg::CMD_BYTE, 8'h62);
        send_item(sha1de_pkg::CMD_BYTE, 8'h63);
        send_item(sha1de_pkg::CMD_FINISH, 8'h00);
    endtask

    // Byte values at the extremes and alternating bit patterns.
    task automatic test_byte_extremes();
        send_item(sha1de_pkg::CMD_BYTE, 8'h00);
        send_item(sha1de_pkg::CMD_BYTE, 8'hFF);
        send_item(sha1de_pkg::CMD_BYTE, 8'h55);
        send_item(sha1de_pkg::CMD_BYTE, 8'hAA);
        send_item(sha1de_pkg::CMD_BYTE, 8'h01);
        send_item(sha1de_pkg::CMD_BYTE, 8'h80);
        send_item(sha1de_pkg::CMD_FINISH, 8'hA5);
    endtask

    // A message, a full pause until its digest is out, then another message.
    task automatic test_drain_pause();
        send_message(5);
        wait_until_drained();
        send_message(2);
    endtask

    // Random messages; about a third straddle the padding and block boundaries.
    task automatic test_random_messages();
        int len;
        while (items_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    case ($urandom_range(0, 8))
                        0: len = 55;
                        1: len = 56;
                        2: len = 57;
                        3: len = 63;
                        4: len = 64;
                        5: len = 65;
                        6: len = 119;
                        7: len = 120;
                        default: len = 128;
                    endcase
                end
                3: len = 0;
                default: len = $urandom_range(1, 24);
            endcase
            send_message(len);
            if ($urandom_range(0, 5) == 0) begin
                wait_until_drained();
            end
        end
        calm = 1'b0;
    endtask

    // Result side: random stall before each digest transaction.
    initial begin : result_sink
        int hold;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            hold = calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Compare every accepted digest transaction with the oldest prediction.
    always @(posedge i_clk) begin : digest_check
        t_digest_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word: expected none, got %h index %0d",
                         $time, o_digest_word, o_word_index);
                error_count++;
            end else begin
                want = digest_q.pop_front();
                words_checked++;
                if (o_digest_word !== want.word) begin
                    $display("%0t: digest word mismatch: expected %h, got %h",
                             $time, want.word, o_digest_word);
                    error_count++;
                end
                if (o_word_index !== want.index) begin
                    $display("%0t: word index mismatch: expected %0d, got %0d",
                             $time, want.index, o_word_index);
                    error_count++;
                end
                if (o_last_word !== want.last) begin
                    $display("%0t: last word mismatch: expected %b, got %b",
                             $time, want.last, o_last_word);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %b, got %b",
                             $time, want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Reset, run the tests in turn, drain and report.
    initial begin
        model_reset();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_message();
        test_abc_message();
        test_byte_extremes();
        test_drain_pause();
        test_random_messages();

        i_valid <= 1'b0;
        while (digest_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        // The length-overflow status needs 2^61 bytes and is out of reach in simulation.
        $display("Sent %0d transactions in %0d messages (longest %0d bytes).",
                 items_sent, messages_done, longest_msg);
        $display("Checked %0d digest words, %0d errors.", words_checked, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
